[hw/rtl/trrd_pkg.sv]
// ---------------------------------------------------------------------------
// trrd_pkg: shared constants and types
// Sizes, record layout and codes of the threshold rising-run detector.
// ---------------------------------------------------------------------------
package trrd_pkg;

   localparam int MAX_ITEMS   = 1024;
   localparam int LEVEL_BITS  = 16;
   localparam int INDEX_BITS  = $clog2(MAX_ITEMS);
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);

   // result queue sizing: three records per transfer plus one in flight
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_PUSH    = 3;

   // record kinds
   localparam logic KIND_RUN    = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic      kind;
      index_type start_pos;
      level_type start_level;
      level_type end_level;
      count_type run_length;
      count_type runs_in_packet;
      logic      last_result;
   } result_type;

   // records produced by one input transfer, packed from slot 0
   typedef struct packed {
      logic [1:0]                num;
      result_type [MAX_PUSH-1:0] rec;
   } push_type;

   // queue status toward the top level
   typedef struct packed {
      logic [QCOUNT_BITS-1:0] count;
      logic                   has_room;
   } queue_stat_type;

endpackage

[hw/rtl/trrd_if.sv]
// ---------------------------------------------------------------------------
// trrd channel interfaces
// Sample input, result output and threshold write channels.
// ---------------------------------------------------------------------------
interface trrd_req_if;
   import trrd_pkg::*;
   logic      valid;
   logic      ready;
   level_type level;
   logic      last_of_packet;
   modport source (output valid, level, last_of_packet, input ready);
   modport sink (input valid, level, last_of_packet, output ready);
endinterface

interface trrd_rsp_if;
   import trrd_pkg::*;
   logic      valid;
   logic      ready;
   logic      kind;
   index_type start_pos;
   level_type start_level;
   level_type end_level;
   count_type run_length;
   count_type runs_in_packet;
   logic      last_result;
   modport source (output valid, kind, start_pos, start_level, end_level,
                   run_length, runs_in_packet, last_result, input ready);
   modport sink (input valid, kind, start_pos, start_level, end_level,
                 run_length, runs_in_packet, last_result, output ready);
endinterface

interface trrd_csr_if;
   import trrd_pkg::*;
   logic      valid;
   logic      ready;
   level_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hw/rtl/threshold_rising_run_detector_top.sv]
// ---------------------------------------------------------------------------
// threshold_rising_run_detector_top: rising-run detector
// Finds runs of non-falling samples that start at or above a threshold.
// ---------------------------------------------------------------------------
// Records are registered into the result queue on their sample transfer.
// Throughput: one sample per cycle while each sample yields at most one
// record and rsp does not stall; the queue drains one record per cycle,
// so a sample with several records blocks new samples until it has room.
// Reset: synchronous; clears run state, queue and threshold (to 0).
module threshold_rising_run_detector_top (
   input  logic        clock,
   input  logic        reset,
   trrd_req_if.sink    req_chan,
   trrd_rsp_if.source  rsp_chan,
   trrd_csr_if.sink    csr_chan
);
   import trrd_pkg::*;

   level_type      threshold_ff;
   logic           accept;
   push_type       push;
   queue_stat_type qstat;

   // threshold register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         threshold_ff <= csr_chan.data;
      end
   end

   // sample transfer whenever the queue can absorb a full burst
   assign req_chan.ready = qstat.has_room;
   assign accept         = req_chan.valid && req_chan.ready;

   trrd_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .level          (req_chan.level),
      .last_of_packet (req_chan.last_of_packet),
      .threshold      (threshold_ff),
      .push           (push)
   );

   trrd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_en (accept),
      .push    (push),
      .stat    (qstat),
      .rsp     (rsp_chan)
   );

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QCOUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // end of packet always leaves a marker to deliver
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_of_packet) |=> rsp_chan.valid)
      else $error("no record after end of packet");

   // nothing offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

   // a transfer out of a single-entry queue with no push empties it
   assert property (@(posedge clock) disable iff (reset)
      (qstat.count == QCOUNT_BITS'(1) && rsp_chan.ready && !accept) |=> !rsp_chan.valid)
      else $error("queue count mismatch");

endmodule

[hw/rtl/trrd_tracker.sv]
// ---------------------------------------------------------------------------
// trrd_tracker: run state and record generation
// Updates the open-run state for each sample and builds up to three records.
// ---------------------------------------------------------------------------
module trrd_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  trrd_pkg::level_type  level,
   input  logic                 last_of_packet,
   input  trrd_pkg::level_type  threshold,
   output trrd_pkg::push_type   push
);
   import trrd_pkg::*;

   localparam count_type MAX_COUNT = COUNT_BITS'(MAX_ITEMS);
   localparam index_type MAX_POS   = INDEX_BITS'(MAX_ITEMS - 1);

   logic      in_run_ff, in_run_in;
   index_type start_index_ff, start_index_in;
   level_type start_level_ff, start_level_in;
   level_type prev_level_ff, prev_level_in;
   count_type run_len_ff, run_len_in;
   index_type position_ff, position_in;
   count_type run_count_ff, run_count_in;

   logic       drop, cont, start, open_run, end_run;
   count_type  len_cont, len_open, count_drop, count_end;
   index_type  idx_open;
   level_type  lvl_open;
   result_type drop_rec, end_rec, marker_rec;
   logic [1:0] num;

   // next state and records for the sample in flight
   always_comb begin
      drop     = in_run_ff && (level < prev_level_ff);
      cont     = in_run_ff && !drop;
      len_cont = (cont && run_len_ff < MAX_COUNT) ? run_len_ff + 1'b1 : run_len_ff;
      count_drop = (drop && run_count_ff < MAX_COUNT) ? run_count_ff + 1'b1
                                                       : run_count_ff;
      start    = !cont && (level >= threshold);
      open_run = cont || start;
      idx_open = start ? position_ff : start_index_ff;
      lvl_open = start ? level : start_level_ff;
      len_open = start ? COUNT_BITS'(1) : len_cont;
      end_run  = last_of_packet && open_run;
      count_end = (end_run && count_drop < MAX_COUNT) ? count_drop + 1'b1
                                                      : count_drop;

      drop_rec = '{kind: KIND_RUN, start_pos: start_index_ff,
                   start_level: start_level_ff, end_level: prev_level_ff,
                   run_length: run_len_ff, runs_in_packet: '0, last_result: 1'b0};
      end_rec = '{kind: KIND_RUN, start_pos: idx_open, start_level: lvl_open,
                  end_level: level, run_length: len_open, runs_in_packet: '0,
                  last_result: 1'b0};
      marker_rec = '{kind: KIND_MARKER, start_pos: '0, start_level: '0,
                     end_level: '0, run_length: '0, runs_in_packet: count_end,
                     last_result: 1'b0};

      // pack records in order: drop run, end-of-packet run, marker
      num = 2'(drop) + 2'(end_run) + 2'(last_of_packet);
      push.num = num;
      push.rec[0] = drop ? drop_rec : (end_run ? end_rec : marker_rec);
      push.rec[1] = (drop && end_run) ? end_rec : marker_rec;
      push.rec[2] = marker_rec;
      for (int i = 0; i < MAX_PUSH; i++) begin
         push.rec[i].last_result = (2'(i) == num - 2'd1);
      end

      in_run_in      = open_run && !last_of_packet;
      start_index_in = idx_open;
      start_level_in = lvl_open;
      prev_level_in  = level;
      run_len_in     = len_open;
      position_in    = last_of_packet ? '0
                     : (position_ff < MAX_POS ? position_ff + 1'b1 : position_ff);
      run_count_in   = last_of_packet ? '0 : count_drop;
   end

   // state update on each sample transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff      <= 1'b0;
         start_index_ff <= '0;
         start_level_ff <= '0;
         prev_level_ff  <= '0;
         run_len_ff     <= '0;
         position_ff    <= '0;
         run_count_ff   <= '0;
      end else if (accept) begin
         in_run_ff      <= in_run_in;
         start_index_ff <= start_index_in;
         start_level_ff <= start_level_in;
         prev_level_ff  <= prev_level_in;
         run_len_ff     <= run_len_in;
         position_ff    <= position_in;
         run_count_ff   <= run_count_in;
      end
   end

endmodule

[hw/rtl/trrd_queue.sv]
// ---------------------------------------------------------------------------
// trrd_queue: result record queue
// Takes up to three records per cycle and hands them out one per transfer.
// ---------------------------------------------------------------------------
module trrd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_en,
   input  trrd_pkg::push_type        push,
   output trrd_pkg::queue_stat_type  stat,
   trrd_rsp_if.source                rsp
);
   import trrd_pkg::*;

   result_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic [1:0]             num_pushed;
   logic                   pop;
   result_type             head;

   // pointer and fill bookkeeping
   always_comb begin
      num_pushed = push_en ? push.num : 2'd0;
      pop        = rsp.valid && rsp.ready;
      wr_ptr_in  = wr_ptr_ff + PTR_BITS'(num_pushed);
      rd_ptr_in  = rd_ptr_ff + PTR_BITS'(pop);
      count_in   = count_ff + QCOUNT_BITS'(num_pushed) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // each entry takes the record whose offset from the write pointer lands on it
   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         logic [PTR_BITS-1:0] offset;
         offset = PTR_BITS'(j) - wr_ptr_ff;
         if (push_en && (QCOUNT_BITS'(offset) < QCOUNT_BITS'(push.num))) begin
            entry_ff[j] <= push.rec[offset[1:0]];
         end
      end
   end

   // head record drives the result channel
   always_comb begin
      head               = entry_ff[rd_ptr_ff];
      rsp.valid          = (count_ff != '0);
      rsp.kind           = head.kind;
      rsp.start_pos      = head.start_pos;
      rsp.start_level    = head.start_level;
      rsp.end_level      = head.end_level;
      rsp.run_length     = head.run_length;
      rsp.runs_in_packet = head.runs_in_packet;
      rsp.last_result    = head.last_result;
      stat.count         = count_ff;
      stat.has_room      = (count_ff <= QCOUNT_BITS'(QUEUE_DEPTH - MAX_PUSH));
   end

endmodule

[bench/threshold_rising_run_detector_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// threshold_rising_run_detector_top_tb: self-checking bench for the detector
// Feeds sample packets through the request channel under several threshold
// settings. Both channels stall in random bursts. Every run record and every
// end-of-packet marker is predicted and checked in order, field by field.
// ---------------------------------------------------------------------------
module threshold_rising_run_detector_top_tb;
   import trrd_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 50;

   typedef struct {
      level_type level;
      logic      last;
   } sample_type;

   logic clock;
   logic reset;

   trrd_req_if req_if ();
   trrd_rsp_if rsp_if ();
   trrd_csr_if csr_if ();

   threshold_rising_run_detector_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // stimulus and expected records
   sample_type sample_queue[$];
   result_type expected_records[$];
   result_type step_records[$];

   int queued_count   = 0;
   int accepted_count = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int take_gap       = 0;
   int stall_pct      = 0;

   // predicted detector state
   level_type threshold_setting = '0;
   logic      run_open          = 1'b0;
   index_type open_start_index  = '0;
   level_type open_start_level  = '0;
   level_type last_level        = '0;
   count_type open_length       = '0;
   index_type next_position     = '0;
   count_type packet_runs       = '0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // emit a run record for the open run and close it
   task automatic close_open_run(input level_type end_level);
      result_type rec;
      rec             = '0;
      rec.kind        = KIND_RUN;
      rec.start_pos   = open_start_index;
      rec.start_level = open_start_level;
      rec.end_level   = end_level;
      rec.run_length  = open_length;
      step_records.push_back(rec);
      if (packet_runs < MAX_ITEMS)
         packet_runs++;
      run_open = 1'b0;
   endtask

   // work out the records caused by one sample transfer
   task automatic predict_sample(input level_type level, input logic last);
      result_type marker;
      step_records.delete();
      if (run_open) begin
         if (level < last_level)
            close_open_run(last_level);
         else if (open_length < MAX_ITEMS)
            open_length++;
      end
      // a dropping sample may start the next run at once
      if (!run_open && level >= threshold_setting) begin
         run_open         = 1'b1;
         open_start_index = next_position;
         open_start_level = level;
         open_length      = COUNT_BITS'(1);
      end
      last_level = level;
      if (next_position < MAX_ITEMS - 1)
         next_position++;
      if (last) begin
         if (run_open)
            close_open_run(level);
         marker                = '0;
         marker.kind           = KIND_MARKER;
         marker.runs_in_packet = packet_runs;
         step_records.push_back(marker);
         run_open      = 1'b0;
         next_position = '0;
         packet_runs   = '0;
      end
      if (step_records.size() > 0)
         step_records[step_records.size() - 1].last_result = 1'b1;
      foreach (step_records[i])
         expected_records.push_back(step_records[i]);
   endtask

   // request driver
   always @(posedge clock) begin
      sample_type upcoming;
      if (reset) begin
         req_if.valid          <= 1'b0;
         req_if.level          <= '0;
         req_if.last_of_packet <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_sample(req_if.level, req_if.last_of_packet);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
               send_gap = $urandom_range(0, 13);
               req_if.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               upcoming = sample_queue.pop_front();
               req_if.valid          <= 1'b1;
               req_if.level          <= upcoming.level;
               req_if.last_of_packet <= upcoming.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_records.size() == 0) begin
               report_mismatch("record transfer with nothing expected");
            end else begin
               want = expected_records.pop_front();
               check_field("kind", int'(rsp_if.kind), int'(want.kind));
               check_field("start_pos", int'(rsp_if.start_pos), int'(want.start_pos));
               check_field("start_level", int'(rsp_if.start_level),
                           int'(want.start_level));
               check_field("end_level", int'(rsp_if.end_level), int'(want.end_level));
               check_field("run_length", int'(rsp_if.run_length), int'(want.run_length));
               check_field("runs_in_packet", int'(rsp_if.runs_in_packet),
                           int'(want.runs_in_packet));
               check_field("last_result", int'(rsp_if.last_result),
                           int'(want.last_result));
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_if.ready <= 1'b0;
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            take_gap = $urandom_range(0, 13);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int clamp_level(input int value);
      if (value < 0)
         return 0;
      if (value > 65535)
         return 65535;
      return value;
   endfunction

   task automatic add_sample(input int level, input logic last);
      sample_type s;
      s.level = level_type'(level);
      s.last  = last;
      sample_queue.push_back(s);
      queued_count++;
   endtask

   // packet of climbs, holds and drops around the threshold, with some noise
   task automatic add_random_packet(input int length, input int th);
      int lvl;
      int pick;
      lvl = clamp_level(th + int'($urandom_range(0, 40)) - 20);
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            lvl = lvl;
         else if (pick < 55)
            lvl = lvl + int'($urandom_range(1, 400));
         else if (pick < 78)
            lvl = lvl - int'($urandom_range(1, 400));
         else if (pick < 92)
            lvl = th + int'($urandom_range(0, 6)) - 3;
         else
            lvl = $urandom_range(0, 65535);
         lvl = clamp_level(lvl);
         add_sample(lvl, i == length - 1);
      end
   endtask

   task automatic add_random_packets(input int target, input int th);
      int added;
      int length;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 99) < 85)
            length = $urandom_range(1, 12);
         else
            length = $urandom_range(13, 48);
         add_random_packet(length, th);
         added += length;
      end
   endtask

   task automatic wait_until_drained(input int settle);
      while (accepted_count != queued_count || expected_records.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // threshold write, only while the detector is idle
   task automatic write_threshold(input level_type value);
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_if.ready);
      threshold_setting = value;
      csr_if.valid <= 1'b0;
   endtask

   // sequence of phases
   initial begin
      int th;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.level          = '0;
      req_if.last_of_packet = 1'b0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.data           = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // lowest threshold: every sample may start a run
      stall_pct = 20;
      write_threshold(16'd0);
      add_sample(0, 1'b1);
      add_sample(65535, 1'b1);
      // drop closes a run and restarts; last sample drops and ends the packet
      add_sample(10, 1'b0);
      add_sample(10, 1'b0);
      add_sample(20, 1'b0);
      add_sample(5, 1'b0);
      add_sample(65535, 1'b0);
      add_sample(7, 1'b0);
      add_sample(3, 1'b1);
      wait_until_drained(SETTLE_CYCLES);

      // highest threshold: only full-scale samples start runs
      stall_pct = 30;
      write_threshold(16'hFFFF);
      add_sample(65534, 1'b0);
      add_sample(65535, 1'b0);
      add_sample(65535, 1'b0);
      add_sample(65534, 1'b1);
      add_sample(0, 1'b1);
      add_sample(65535, 1'b1);
      add_random_packets(35, 65535);
      wait_until_drained(SETTLE_CYCLES);

      // mid threshold, with a full drain in the middle of a packet
      stall_pct = 10;
      th = $urandom_range(1, 65534);
      write_threshold(level_type'(th));
      add_random_packets(35, th);
      for (int i = 0; i < 5; i++)
         add_sample(clamp_level(th + i * 3), 1'b0);
      wait_until_drained(0);
      add_random_packets(35, th);
      wait_until_drained(SETTLE_CYCLES);

      stall_pct = 40;
      th = $urandom_range(1, 65534);
      write_threshold(level_type'(th));
      add_random_packets(70, th);
      wait_until_drained(SETTLE_CYCLES);

      // closing stretch without stalls
      stall_pct = 0;
      th = $urandom_range(1, 65534);
      write_threshold(level_type'(th));
      add_random_packets(55, th);
      wait_until_drained(10);

      if (expected_records.size() != 0)
         report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
